[rtl/hub75_pkg.sv]
// shared types, constants and register codes of the hub75 bcm scan generator
// no dependencies; imported by the top level, the scan sequencer and the colour stage
`default_nettype none

package hub75_pkg;

  // default sizing of the frame store
  localparam int unsigned MAX_PANEL_WIDTH_DEF = 64;
  localparam int unsigned MAX_HEIGHT_DEF      = 32;
  localparam int unsigned MAX_PANELS_DEF      = 4;

  // pin word layout
  localparam int unsigned LAT_BIT  = 6;
  localparam int unsigned OE_BIT   = 7;
  localparam int unsigned ADDR_BIT = 8;
  localparam int unsigned OE2_BIT  = 13;
  localparam int unsigned PIN_W    = 14;
  localparam int unsigned ROW_W    = 4;

  // blanking samples at the end of each plane
  localparam int unsigned BLANK_LEN = 3;

  // gamma table
  localparam int unsigned GAMMA_DEPTH = 32;
  localparam int unsigned GAMMA_AW    = 5;

  // register reset values
  localparam logic [6:0] PANEL_WIDTH_RST  = 7'd64;
  localparam logic [5:0] PANEL_HEIGHT_RST = 6'd32;
  localparam logic [2:0] PANEL_COUNT_RST  = 3'd1;
  localparam logic [3:0] PLANE_COUNT_RST  = 4'd5;
  localparam logic [1:0] CHAIN_MODE_RST   = 2'd0;

  typedef enum logic [1:0] {
    REQ_PIXEL = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_GAMMA = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_SINGLE   = 2'd0,
    MODE_PARALLEL = 2'd1,
    MODE_SERIES   = 2'd2
  } chain_mode_e;

  typedef enum logic [2:0] {
    CFG_PANEL_WIDTH  = 3'd0,
    CFG_PANEL_HEIGHT = 3'd1,
    CFG_PANEL_COUNT  = 3'd2,
    CFG_PLANE_COUNT  = 3'd3,
    CFG_CHAIN_MODE   = 3'd4,
    CFG_GAMMA_ON     = 3'd5,
    CFG_SECOND_OE    = 3'd6,
    CFG_PANEL_FLIPS  = 3'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    PH_PIXEL = 2'd0,
    PH_BCM   = 2'd1,
    PH_BLANK = 2'd2
  } phase_e;

  // one input beat
  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] pixel_x;
    logic [4:0] pixel_y;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [4:0] gamma_index;
    logic [7:0] gamma_level;
  } req_t;

  // one output beat
  typedef struct packed {
    logic [13:0] pin_word;
    logic        frame_last;
  } rsp_t;

  // clamped geometry and mode derived from the registers
  typedef struct packed {
    logic [6:0] w;
    logic [4:0] rows;
    logic [3:0] planes;
    logic [8:0] total;
    logic       par;
    logic       series;
    logic       oe2_en;
    logic [7:0] flips;
  } geom_t;

  // per-sample control from the scan sequencer
  typedef struct packed {
    logic             is_pixel;
    logic [2:0]       plane;
    logic [PIN_W-1:0] word;
    logic             last;
  } scan_ctrl_t;

endpackage

`default_nettype wire

[rtl/hub75_bcm_scan_generator.sv]
// hub75 bcm scan generator, top level: registers, frame store, pipeline.
// a tick beat's pin word passes stage 1, stage 2 and the output register. one
// beat per cycle is taken unless an output stall, the clearing pass or a register
// write stalls input, set by the single frame store read per sample and the
// gamma read. reset restores registers and scan counters; a clearing pass
// then writes black to all MAX_PANEL_WIDTH*MAX_PANELS*MAX_HEIGHT entries.
`default_nettype none

module hub75_bcm_scan_generator #(
  parameter int unsigned MAX_PANEL_WIDTH = hub75_pkg::MAX_PANEL_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT      = hub75_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_PANELS      = hub75_pkg::MAX_PANELS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hub75_pkg::req_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hub75_pkg::rsp_t   out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [7:0]        cfg_data_i
);

  import hub75_pkg::*;

  localparam int unsigned STRIDE      = MAX_PANEL_WIDTH * MAX_PANELS;
  localparam int unsigned STORE_DEPTH = STRIDE * MAX_HEIGHT;
  localparam int unsigned FA_W        = $clog2(STORE_DEPTH);

  logic [6:0] pw_q;
  logic [5:0] ph_q;
  logic [2:0] pc_q;
  logic [3:0] plc_q;
  logic [1:0] mode_q;
  logic       gon_q;
  logic       oe2_q;
  logic [7:0] flips_q;

  geom_t      geom;
  logic [5:0] hc;
  logic [2:0] np;

  logic            clr_q;
  logic [FA_W-1:0] clr_addr_q;
  logic            resync_q;

  logic            en, out_free;
  logic            acc, tick_acc, pix_acc, gam_acc, pix_ok;
  logic [FA_W-1:0] pix_addr, fr_waddr, up_addr, lo_addr;
  logic            fr_we;
  logic [23:0]     fr_wdata, pix_up, pix_lo;

  scan_ctrl_t       ctrl0, ctrl1_q, ctrl2_q;
  logic             v1_q, v2_q;
  logic [5:0]       rgb;
  logic [PIN_W-1:0] word;
  logic             out_valid_q;
  rsp_t             out_data_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q    <= PANEL_WIDTH_RST;
      ph_q    <= PANEL_HEIGHT_RST;
      pc_q    <= PANEL_COUNT_RST;
      plc_q   <= PLANE_COUNT_RST;
      mode_q  <= CHAIN_MODE_RST;
      gon_q   <= 1'b0;
      oe2_q   <= 1'b0;
      flips_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PANEL_WIDTH:  pw_q    <= cfg_data_i[6:0];
        CFG_PANEL_HEIGHT: ph_q    <= cfg_data_i[5:0];
        CFG_PANEL_COUNT:  pc_q    <= cfg_data_i[2:0];
        CFG_PLANE_COUNT:  plc_q   <= cfg_data_i[3:0];
        CFG_CHAIN_MODE:   mode_q  <= cfg_data_i[1:0];
        CFG_GAMMA_ON:     gon_q   <= cfg_data_i[0];
        CFG_SECOND_OE:    oe2_q   <= cfg_data_i[0];
        CFG_PANEL_FLIPS:  flips_q <= cfg_data_i;
      endcase
    end
  end

  // clamped geometry
  always_comb begin
    geom = '0;
    if (pw_q == 7'd0) begin
      geom.w = 7'd1;
    end else if (pw_q > 7'(MAX_PANEL_WIDTH)) begin
      geom.w = 7'(MAX_PANEL_WIDTH);
    end else begin
      geom.w = pw_q;
    end
    if (ph_q < 6'd2) begin
      hc = 6'd2;
    end else if (ph_q > 6'(MAX_HEIGHT)) begin
      hc = 6'(MAX_HEIGHT);
    end else begin
      hc = ph_q;
    end
    geom.rows = hc[5:1];
    if (pc_q == 3'd0) begin
      np = 3'd1;
    end else if (pc_q > 3'(MAX_PANELS)) begin
      np = 3'(MAX_PANELS);
    end else begin
      np = pc_q;
    end
    if (plc_q == 4'd0) begin
      geom.planes = 4'd1;
    end else if (plc_q > 4'd8) begin
      geom.planes = 4'd8;
    end else begin
      geom.planes = plc_q;
    end
    geom.total  = 9'(geom.w) * 9'(np);
    geom.par    = mode_q == MODE_PARALLEL;
    geom.series = mode_q == MODE_SERIES;
    geom.oe2_en = oe2_q;
    geom.flips  = flips_q;
  end

  // clearing pass after reset, one-cycle resync after a register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      resync_q   <= 1'b0;
    end else begin
      resync_q <= cfg_valid_i;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + FA_W'(1);
        if (clr_addr_q == FA_W'(STORE_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  // pipeline advance and input acceptance
  assign out_free   = !out_valid_q || !out_stall_i;
  assign en         = out_free || !v2_q;
  assign in_stall_o = clr_q || resync_q || !en;
  assign acc        = in_valid_i && !in_stall_o;
  assign tick_acc   = acc && (in_data_i.req_type == REQ_TICK);
  assign pix_acc    = acc && (in_data_i.req_type == REQ_PIXEL);
  assign gam_acc    = acc && (in_data_i.req_type == REQ_GAMMA);

  // pixel write range check and address
  assign pix_ok   = (9'(in_data_i.pixel_x) < geom.total)
                 && (6'(in_data_i.pixel_y) < {geom.rows, 1'b0});
  assign pix_addr = FA_W'(in_data_i.pixel_y * STRIDE) + FA_W'(in_data_i.pixel_x);

  assign fr_we    = clr_q || (pix_acc && pix_ok);
  assign fr_waddr = clr_q ? clr_addr_q : pix_addr;
  assign fr_wdata = clr_q ? '0 : {in_data_i.red, in_data_i.green, in_data_i.blue};

  hub75_scan #(
    .MAX_PANEL_WIDTH (MAX_PANEL_WIDTH),
    .MAX_HEIGHT      (MAX_HEIGHT),
    .MAX_PANELS      (MAX_PANELS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tick_i    (tick_acc),
    .resync_i  (resync_q),
    .geom_i    (geom),
    .ctrl_o    (ctrl0),
    .up_addr_o (up_addr),
    .lo_addr_o (lo_addr)
  );

  // frame store, upper and lower pixel read per sample
  hub75_ram #(
    .WIDTH (24),
    .DEPTH (STORE_DEPTH)
  ) u_frame (
    .clk_i     (clk_i),
    .we_i      (fr_we),
    .waddr_i   (fr_waddr),
    .wdata_i   (fr_wdata),
    .re_i      (en),
    .raddr_a_i (up_addr),
    .raddr_b_i (lo_addr),
    .rdata_a_o (pix_up),
    .rdata_b_o (pix_lo)
  );

  hub75_gamma u_gamma (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .gw_i       (gam_acc),
    .gw_index_i (in_data_i.gamma_index),
    .gw_level_i (in_data_i.gamma_level),
    .gamma_on_i (gon_q),
    .pix_up_i   (pix_up),
    .pix_lo_i   (pix_lo),
    .plane_i    (ctrl2_q.plane),
    .rgb_o      (rgb)
  );

  // stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= tick_acc;
      v2_q <= v1_q;
    end
  end

  // stage control payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      ctrl1_q <= ctrl0;
      ctrl2_q <= ctrl1_q;
    end
  end

  // pin word assembly
  always_comb begin
    word = ctrl2_q.word;
    if (ctrl2_q.is_pixel) begin
      word[5:0] = rgb;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q.pin_word   <= word;
      out_data_q.frame_last <= ctrl2_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // latch only on column samples, which keep the panel dark
  a_latch_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pin_word[LAT_BIT] |-> out_data_o.pin_word[OE_BIT])
    else $error("latch beat with output enabled");

  // frame end falls on a blanking sample
  a_last_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_last
      |-> out_data_o.pin_word[OE_BIT] && !out_data_o.pin_word[LAT_BIT])
    else $error("frame end not on a blanking beat");

  // a finished sample waits in the last stage while the output is held
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && out_valid_q && out_stall_i |=> v2_q && $stable(ctrl2_q))
    else $error("pipeline sample lost under output stall");

endmodule

`default_nettype wire

[rtl/hub75_ram.sv]
// generic single-write, dual-read synchronous ram with registered read data
// read returns the old contents on a same-cycle write; no dependencies
`default_nettype none

module hub75_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // write port and two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

[rtl/hub75_scan.sv]
// scan sequencer: row, plane, column and phase counters, pin control bits
// and frame store addresses of the upper and lower pixel; uses hub75_pkg
`default_nettype none

module hub75_scan #(
  parameter int unsigned MAX_PANEL_WIDTH = hub75_pkg::MAX_PANEL_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT      = hub75_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned MAX_PANELS      = hub75_pkg::MAX_PANELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tick_i,
  input  logic                 resync_i,
  input  hub75_pkg::geom_t     geom_i,
  output hub75_pkg::scan_ctrl_t ctrl_o,
  output logic [$clog2(MAX_PANEL_WIDTH*MAX_PANELS*MAX_HEIGHT)-1:0] up_addr_o,
  output logic [$clog2(MAX_PANEL_WIDTH*MAX_PANELS*MAX_HEIGHT)-1:0] lo_addr_o
);

  import hub75_pkg::*;

  localparam int unsigned STRIDE = MAX_PANEL_WIDTH * MAX_PANELS;
  localparam int unsigned FA_W   = $clog2(STRIDE * MAX_HEIGHT);
  localparam int unsigned COL_W  = $clog2(STRIDE);
  localparam int unsigned LOC_W  = $clog2(MAX_PANEL_WIDTH);

  logic [ROW_W-1:0] row_q, row_d, row;
  logic [2:0]       plane_q, plane_d, plane;
  logic [COL_W-1:0] col_q, col_d, col, col_inc;
  logic [LOC_W-1:0] loc_q, loc_d, loc, loc_r;
  logic [1:0]       pnl_q, pnl_d, pnl, pnl_r;
  phase_e           phase_q, phase_d, phase;
  logic [7:0]       cnt_q, cnt_d, cnt;
  logic [8:0]       len_cur, len;
  logic             bad;
  logic             col_last, loc_last, latch;
  logic             bcm_done, blank_done, plane_last, row_last;
  logic             hflip, vflip;
  logic [8:0]       col_x;
  logic [5:0]       up_v, lo_v;

  assign len_cur = 9'd1 << plane_q;
  assign len     = 9'd1 << plane;

  // panel and in-panel column recomputed from the column after a register write
  always_comb begin
    pnl_r = '0;
    for (int k = 1; k < MAX_PANELS; k++) begin
      if (9'(col_q) >= 9'(k * geom_i.w)) begin
        pnl_r = pnl_r + 2'd1;
      end
    end
    loc_r = LOC_W'(9'(col_q) - 9'(pnl_r) * 9'(geom_i.w));
  end

  // out-of-range counters restart the scan
  always_comb begin
    bad = (5'(row_q) >= geom_i.rows) || (4'(plane_q) >= geom_i.planes)
       || (9'(col_q) >= geom_i.total)
       || ((phase_q == PH_BLANK) && (cnt_q >= 8'(BLANK_LEN)))
       || ((phase_q == PH_BCM) && (9'(cnt_q) >= len_cur));
    row   = bad ? '0 : row_q;
    plane = bad ? '0 : plane_q;
    col   = bad ? '0 : col_q;
    loc   = bad ? '0 : loc_q;
    pnl   = bad ? '0 : pnl_q;
    phase = bad ? PH_PIXEL : phase_q;
    cnt   = bad ? '0 : cnt_q;
  end

  // position flags
  assign col_inc    = col + COL_W'(1);
  assign col_last   = (9'(col) + 9'd1) >= geom_i.total;
  assign loc_last   = 7'(loc) == (geom_i.w - 7'd1);
  assign bcm_done   = (9'(cnt) + 9'd1) >= len;
  assign blank_done = (cnt + 8'd1) >= 8'(BLANK_LEN);
  assign plane_last = (4'(plane) + 4'd1) >= geom_i.planes;
  assign row_last   = (5'(row) + 5'd1) >= geom_i.rows;

  // latch column by chain mode
  always_comb begin
    if (geom_i.par) begin
      latch = loc_last;
    end else if (geom_i.series) begin
      latch = 9'(col) == (geom_i.total - 9'd1);
    end else begin
      latch = 9'(col) == (9'(geom_i.w) - 9'd1);
    end
  end

  // panel flips and frame store addresses
  always_comb begin
    hflip = geom_i.flips[{pnl, 1'b0}];
    vflip = geom_i.flips[{pnl, 1'b1}];
    col_x = hflip ? 9'(col) + 9'(geom_i.w) - 9'd1 - 9'({loc, 1'b0}) : 9'(col);
    if (vflip) begin
      up_v = 6'({geom_i.rows, 1'b0}) - 6'd1 - 6'(row);
      lo_v = 6'(geom_i.rows) - 6'd1 - 6'(row);
    end else begin
      up_v = 6'(row);
      lo_v = 6'(row) + 6'(geom_i.rows);
    end
    up_addr_o = FA_W'(up_v * STRIDE) + FA_W'(col_x);
    lo_addr_o = FA_W'(lo_v * STRIDE) + FA_W'(col_x);
  end

  // control bits of the current sample
  always_comb begin
    ctrl_o = '0;
    ctrl_o.is_pixel = phase == PH_PIXEL;
    ctrl_o.plane    = plane;
    ctrl_o.word[ADDR_BIT +: ROW_W] = row;
    unique case (phase)
      PH_PIXEL: begin
        ctrl_o.word[OE_BIT]  = 1'b1;
        ctrl_o.word[OE2_BIT] = geom_i.par & geom_i.oe2_en;
        ctrl_o.word[LAT_BIT] = latch;
      end
      PH_BCM: begin
        if (geom_i.par) begin
          if (pnl == 2'd0) begin
            ctrl_o.word[OE2_BIT] = geom_i.oe2_en;
          end else if (pnl == 2'd1) begin
            ctrl_o.word[OE_BIT] = 1'b1;
          end
        end
      end
      default: begin
        ctrl_o.word[OE_BIT]  = 1'b1;
        ctrl_o.word[OE2_BIT] = geom_i.oe2_en;
      end
    endcase
    ctrl_o.last = (phase == PH_BLANK) && blank_done && plane_last && row_last;
  end

  // next scan position
  always_comb begin
    row_d   = row_q;
    plane_d = plane_q;
    col_d   = col_q;
    loc_d   = loc_q;
    pnl_d   = pnl_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (resync_i) begin
      loc_d = loc_r;
      pnl_d = pnl_r;
    end
    if (tick_i) begin
      row_d   = row;
      plane_d = plane;
      col_d   = col;
      loc_d   = loc;
      pnl_d   = pnl;
      phase_d = phase;
      cnt_d   = cnt;
      unique case (phase)
        PH_PIXEL: begin
          if ((geom_i.par && loc_last) || col_last) begin
            phase_d = PH_BCM;
            cnt_d   = '0;
          end else begin
            col_d = col_inc;
            if (loc_last) begin
              loc_d = '0;
              pnl_d = pnl + 2'd1;
            end else begin
              loc_d = loc + LOC_W'(1);
            end
          end
        end
        PH_BCM: begin
          cnt_d = cnt + 8'd1;
          if (bcm_done) begin
            cnt_d = '0;
            if (geom_i.par && !col_last) begin
              col_d   = col_inc;
              phase_d = PH_PIXEL;
              if (loc_last) begin
                loc_d = '0;
                pnl_d = pnl + 2'd1;
              end else begin
                loc_d = loc + LOC_W'(1);
              end
            end else begin
              phase_d = PH_BLANK;
            end
          end
        end
        default: begin
          cnt_d = cnt + 8'd1;
          if (blank_done) begin
            cnt_d   = '0;
            col_d   = '0;
            loc_d   = '0;
            pnl_d   = '0;
            phase_d = PH_PIXEL;
            if (plane_last) begin
              plane_d = '0;
              row_d   = row_last ? '0 : row + ROW_W'(1);
            end else begin
              plane_d = plane + 3'd1;
            end
          end
        end
      endcase
    end
  end

  // scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      plane_q <= '0;
      col_q   <= '0;
      loc_q   <= '0;
      pnl_q   <= '0;
      phase_q <= PH_PIXEL;
      cnt_q   <= '0;
    end else begin
      row_q   <= row_d;
      plane_q <= plane_d;
      col_q   <= col_d;
      loc_q   <= loc_d;
      pnl_q   <= pnl_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[rtl/hub75_gamma.sv]
// colour stage: top five bits of each channel, gamma lookup in three
// two-port table copies, bit-plane select; uses hub75_pkg and hub75_ram
`default_nettype none

module hub75_gamma (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               gw_i,
  input  logic [hub75_pkg::GAMMA_AW-1:0]     gw_index_i,
  input  logic [7:0]                         gw_level_i,
  input  logic                               gamma_on_i,
  input  logic [23:0]                        pix_up_i,
  input  logic [23:0]                        pix_lo_i,
  input  logic [2:0]                         plane_i,
  output logic [5:0]                         rgb_o
);

  import hub75_pkg::*;

  logic [GAMMA_DEPTH-1:0]        valid_q;
  logic [2:0][GAMMA_AW-1:0]      cu, cl;
  logic [2:0][GAMMA_AW-1:0]      cu_q, cl_q;
  logic [2:0]                    vu_q, vl_q;
  logic [2:0][7:0]               gu, gl;
  logic [2:0][7:0]               lvl_u, lvl_l;

  // one table copy per channel, read for the upper and the lower pixel
  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    assign cu[ch] = pix_up_i[23 - 8*ch -: GAMMA_AW];
    assign cl[ch] = pix_lo_i[23 - 8*ch -: GAMMA_AW];

    hub75_ram #(
      .WIDTH (8),
      .DEPTH (GAMMA_DEPTH)
    ) u_tab (
      .clk_i     (clk_i),
      .we_i      (gw_i),
      .waddr_i   (gw_index_i),
      .wdata_i   (gw_level_i),
      .re_i      (en_i),
      .raddr_a_i (cu[ch]),
      .raddr_b_i (cl[ch]),
      .rdata_a_o (gu[ch]),
      .rdata_b_o (gl[ch])
    );

    // entries never written hold their own index
    assign lvl_u[ch] = (gamma_on_i && vu_q[ch]) ? gu[ch] : 8'(cu_q[ch]);
    assign lvl_l[ch] = (gamma_on_i && vl_q[ch]) ? gl[ch] : 8'(cl_q[ch]);
    assign rgb_o[ch]     = lvl_u[ch][plane_i];
    assign rgb_o[ch + 3] = lvl_l[ch][plane_i];
  end

  // written-entry flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (gw_i) begin
      valid_q[gw_index_i] <= 1'b1;
    end
  end

  // raw levels and flags alongside the table read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cu_q <= cu;
      cl_q <= cl;
      for (int ch = 0; ch < 3; ch++) begin
        vu_q[ch] <= valid_q[cu[ch]];
        vl_q[ch] <= valid_q[cl[ch]];
      end
    end
  end

endmodule

`default_nettype wire

[dv/hub75_bcm_scan_generator_tb.sv]
// self-checking testbench for the hub75 bcm scan generator: a queue-fed driver,
// a checking monitor and an in-bench scan predictor over several panel geometries
// depends on rtl/hub75_pkg.sv and rtl/hub75_bcm_scan_generator.sv
`timescale 1ns / 1ps

module hub75_bcm_scan_generator_tb;
  import hub75_pkg::*;

  localparam int unsigned STRIDE       = MAX_PANEL_WIDTH_DEF * MAX_PANELS_DEF;
  localparam int unsigned FRAME_DEPTH  = STRIDE * MAX_HEIGHT_DEF;
  localparam int unsigned SETTLE_CYC   = 8;
  localparam int unsigned END_CYC      = 20;
  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int unsigned MAX_PRINTED  = 30;
  localparam logic [1:0]  REQ_UNUSED   = 2'd3;
  localparam logic [1:0]  MODE_UNUSED  = 2'd3;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  req_t in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i  = '0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_data_o;
  logic cfg_ready_o;

  // scan predictor state: register copies, stores and scan counters
  logic [6:0]  cfg_width;
  logic [5:0]  cfg_height;
  logic [2:0]  cfg_count;
  logic [3:0]  cfg_planes;
  logic [1:0]  cfg_mode;
  logic        cfg_gamma_on;
  logic        cfg_oe2;
  logic [7:0]  cfg_flips;
  logic [23:0] frame_mem [FRAME_DEPTH];
  logic [7:0]  gamma_mem [GAMMA_DEPTH];
  int unsigned scan_row, scan_plane, scan_col, phase_cnt;
  phase_e      scan_ph;

  req_t pending_reqs[$];
  rsp_t pin_words_due[$];
  rsp_t due_word;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;
  int unsigned accepted_count = 0;
  int unsigned words_checked  = 0;
  int unsigned frames_seen    = 0;
  int unsigned geometries     = 0;
  int unsigned cycle_count    = 0;

  hub75_bcm_scan_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pin words still due", cycle_count,
               pin_words_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int unsigned clampu(input int unsigned v, input int unsigned lo,
                                         input int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic colour_bit(input logic [7:0] v, input int unsigned plane);
    logic [7:0] c;
    c = {3'b000, v[7:3]};
    if (cfg_gamma_on) c = gamma_mem[v[7:3]];
    return c[plane[2:0]];
  endfunction

  // bit 0 red, bit 1 green, bit 2 blue
  function automatic logic [2:0] pixel_rgb(input logic [23:0] px, input int unsigned plane);
    return {colour_bit(px[7:0], plane), colour_bit(px[15:8], plane),
            colour_bit(px[23:16], plane)};
  endfunction

  function automatic void reset_model();
    cfg_width    = PANEL_WIDTH_RST;
    cfg_height   = PANEL_HEIGHT_RST;
    cfg_count    = PANEL_COUNT_RST;
    cfg_planes   = PLANE_COUNT_RST;
    cfg_mode     = CHAIN_MODE_RST;
    cfg_gamma_on = 1'b0;
    cfg_oe2      = 1'b0;
    cfg_flips    = '0;
    for (int i = 0; i < FRAME_DEPTH; i++) frame_mem[i] = '0;
    for (int i = 0; i < GAMMA_DEPTH; i++) gamma_mem[i] = 8'(i);
    scan_row   = 0;
    scan_plane = 0;
    scan_col   = 0;
    phase_cnt  = 0;
    scan_ph    = PH_PIXEL;
  endfunction

  function automatic void apply_reg(input cfg_reg_e idx, input logic [7:0] v);
    case (idx)
      CFG_PANEL_WIDTH:  cfg_width    = v[6:0];
      CFG_PANEL_HEIGHT: cfg_height   = v[5:0];
      CFG_PANEL_COUNT:  cfg_count    = v[2:0];
      CFG_PLANE_COUNT:  cfg_planes   = v[3:0];
      CFG_CHAIN_MODE:   cfg_mode     = v[1:0];
      CFG_GAMMA_ON:     cfg_gamma_on = v[0];
      CFG_SECOND_OE:    cfg_oe2      = v[0];
      CFG_PANEL_FLIPS:  cfg_flips    = v;
      default: ;
    endcase
  endfunction

  // apply one accepted beat: a write updates a store, a tick advances the predicted scan and queues its pin word
  function automatic void predict_scan(input req_t rq);
    int unsigned w, rows, np, planes, total, x, y, p, loc, up, lo, col;
    logic par, latch, last;
    logic [PIN_W-1:0] word, oe2;
    rsp_t r;
    w      = clampu(int'(cfg_width), 1, MAX_PANEL_WIDTH_DEF);
    rows   = clampu(int'(cfg_height), 2, MAX_HEIGHT_DEF) / 2;
    np     = clampu(int'(cfg_count), 1, MAX_PANELS_DEF);
    planes = clampu(int'(cfg_planes), 1, 8);
    total  = w * np;
    par    = (cfg_mode == MODE_PARALLEL);
    oe2    = '0;
    if (cfg_oe2) oe2[OE2_BIT] = 1'b1;
    last   = 1'b0;
    word   = '0;
    case (rq.req_type)
      REQ_PIXEL: begin
        x = int'(rq.pixel_x);
        y = int'(rq.pixel_y);
        if (x < total && y < rows * 2)
          frame_mem[(y * STRIDE + x) % FRAME_DEPTH] = {rq.red, rq.green, rq.blue};
      end
      REQ_GAMMA: gamma_mem[rq.gamma_index] = rq.gamma_level;
      REQ_TICK: begin
        // a geometry change can leave the counters outside the new scan
        if (scan_row >= rows || scan_plane >= planes || scan_col >= total ||
            (scan_ph == PH_BLANK && phase_cnt >= BLANK_LEN) ||
            (scan_ph == PH_BCM && phase_cnt >= (1 << scan_plane))) begin
          scan_row   = 0;
          scan_plane = 0;
          scan_col   = 0;
          scan_ph    = PH_PIXEL;
          phase_cnt  = 0;
        end
        word[ADDR_BIT +: ROW_W] = scan_row[ROW_W-1:0];
        if (scan_ph == PH_PIXEL) begin
          p   = scan_col / w;
          loc = scan_col % w;
          up  = scan_row;
          lo  = scan_row + rows;
          col = scan_col;
          if (cfg_flips[2*p]) col = p * w + (w - 1 - loc);
          if (cfg_flips[2*p+1]) begin
            up = (rows - 1 - scan_row) + rows;
            lo = rows - 1 - scan_row;
          end
          word[2:0] = pixel_rgb(frame_mem[(up * STRIDE + col) % FRAME_DEPTH], scan_plane);
          word[5:3] = pixel_rgb(frame_mem[(lo * STRIDE + col) % FRAME_DEPTH], scan_plane);
          word[OE_BIT] = 1'b1;
          if (par) begin
            word  = word | oe2;
            latch = (loc == w - 1);
          end else if (cfg_mode == MODE_SERIES) begin
            latch = (scan_col == total - 1);
          end else begin
            latch = (scan_col == w - 1);
          end
          if (latch) word[LAT_BIT] = 1'b1;
          if (par && loc == w - 1) begin
            scan_ph   = PH_BCM;
            phase_cnt = 0;
          end else if (scan_col + 1 < total) begin
            scan_col++;
          end else begin
            scan_ph   = PH_BCM;
            phase_cnt = 0;
          end
        end else if (scan_ph == PH_BCM) begin
          // parallel mode lights one panel at a time
          if (par) begin
            p = scan_col / w;
            if (p == 0) word = word | oe2;
            else if (p == 1) word[OE_BIT] = 1'b1;
          end
          phase_cnt++;
          if (phase_cnt >= (1 << scan_plane)) begin
            phase_cnt = 0;
            if (par && scan_col + 1 < total) begin
              scan_col++;
              scan_ph = PH_PIXEL;
            end else begin
              scan_ph = PH_BLANK;
            end
          end
        end else begin
          word[OE_BIT] = 1'b1;
          word = word | oe2;
          phase_cnt++;
          if (phase_cnt >= BLANK_LEN) begin
            phase_cnt = 0;
            scan_col  = 0;
            scan_ph   = PH_PIXEL;
            scan_plane++;
            if (scan_plane >= planes) begin
              scan_plane = 0;
              scan_row++;
              if (scan_row >= rows) begin
                scan_row = 0;
                last     = 1'b1;
              end
            end
          end
        end
        r.pin_word   = word;
        r.frame_last = last;
        pin_words_due.push_back(r);
      end
      default: ;
    endcase
  endfunction

  function automatic req_t make_req(input logic [1:0] kind, input logic [7:0] x,
                                    input logic [4:0] y, input logic [7:0] red,
                                    input logic [7:0] green, input logic [7:0] blue,
                                    input logic [4:0] gidx, input logic [7:0] glvl);
    req_t rq;
    rq.req_type    = kind;
    rq.pixel_x     = x;
    rq.pixel_y     = y;
    rq.red         = red;
    rq.green       = green;
    rq.blue        = blue;
    rq.gamma_index = gidx;
    rq.gamma_level = glvl;
    return rq;
  endfunction

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly ticks and in-range pixel writes, some gamma writes and noise
  function automatic req_t random_request(input int unsigned tick_pct);
    req_t rq;
    logic [63:0] bits;
    int unsigned roll, total, height;
    bits   = {$urandom(), $urandom()};
    rq     = bits[$bits(req_t)-1:0];
    total  = clampu(int'(cfg_width), 1, MAX_PANEL_WIDTH_DEF) *
             clampu(int'(cfg_count), 1, MAX_PANELS_DEF);
    height = (clampu(int'(cfg_height), 2, MAX_HEIGHT_DEF) / 2) * 2;
    roll   = $urandom_range(0, 99);
    if (roll < tick_pct) begin
      rq.req_type = REQ_TICK;
    end else if (roll < tick_pct + (100 - tick_pct) * 3 / 4) begin
      rq.req_type = REQ_PIXEL;
      if ($urandom_range(0, 99) < 88) begin
        rq.pixel_x = 8'($urandom_range(0, total - 1));
        rq.pixel_y = 5'($urandom_range(0, height - 1));
      end
      rq.red   = random_level();
      rq.green = random_level();
      rq.blue  = random_level();
    end else if (roll < 98) begin
      rq.req_type = REQ_GAMMA;
    end else begin
      rq.req_type = REQ_UNUSED;
    end
    return rq;
  endfunction

  // beat driver, fed from the pending queue
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_scan(in_data_i);
        accepted_count++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data_i  <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // pin word monitor and checker
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (pin_words_due.size() == 0) begin
          report_error($sformatf("pin word %h with none due", out_data_o.pin_word));
        end else begin
          due_word = pin_words_due.pop_front();
          if (out_data_o.pin_word !== due_word.pin_word)
            report_error($sformatf("pin_word got %h want %h (word %0d)",
                                   out_data_o.pin_word, due_word.pin_word, words_checked));
          if (out_data_o.frame_last !== due_word.frame_last)
            report_error($sformatf("frame_last got %b want %b (word %0d)",
                                   out_data_o.frame_last, due_word.frame_last,
                                   words_checked));
          words_checked++;
          if (due_word.frame_last) frames_seen++;
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid_i || pin_words_due.size() != 0);
  endtask

  // called right after a rising edge with the block idle
  task automatic write_reg(input cfg_reg_e idx, input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    apply_reg(idx, v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [7:0] w, input logic [7:0] h, input logic [7:0] n,
                           input logic [7:0] pl, input logic [1:0] md, input logic gam,
                           input logic oe, input logic [7:0] fl, input int unsigned items,
                           input int unsigned tick_pct);
    req_t rq;
    int unsigned added;
    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    write_reg(CFG_PANEL_WIDTH, w);
    write_reg(CFG_PANEL_HEIGHT, h);
    write_reg(CFG_PANEL_COUNT, n);
    write_reg(CFG_PLANE_COUNT, pl);
    write_reg(CFG_CHAIN_MODE, 8'(md));
    write_reg(CFG_GAMMA_ON, 8'(gam));
    write_reg(CFG_SECOND_OE, 8'(oe));
    write_reg(CFG_PANEL_FLIPS, fl);
    geometries++;
    @(negedge clk_i);
    // two bursts with a full drain between them
    for (int half = 0; half < 2; half++) begin
      added = 0;
      while (added < items / 2) begin
        rq = random_request(tick_pct);
        pending_reqs.push_back(rq);
        if (rq.req_type != REQ_UNUSED) added++;
      end
      if (half == 0) wait_drained();
    end
  endtask

  initial begin
    reset_model();
    send_idle_pct  = 33;
    recv_stall_pct = 54;

    // directed: corner pixels, ignored writes, gamma entries, unknown request, scan start
    pending_reqs.push_back(make_req(REQ_PIXEL, 8'd0, 5'd0, 8'hFF, 8'hFF, 8'hFF, 5'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_PIXEL, 8'd0, 5'd16, 8'h08, 8'h80, 8'hF8, 5'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_PIXEL, 8'd1, 5'd0, 8'h18, 8'h00, 8'hFF, 5'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_PIXEL, 8'd1, 5'd16, 8'h10, 8'h20, 8'h40, 5'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_PIXEL, 8'd255, 5'd31, 8'h55, 8'hAA, 8'h55, 5'd0,
                                    8'd0));
    pending_reqs.push_back(make_req(REQ_PIXEL, 8'd63, 5'd31, 8'hFF, 8'h00, 8'hFF, 5'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_PIXEL, 8'd64, 5'd0, 8'hFF, 8'hFF, 8'hFF, 5'd0, 8'd0));
    pending_reqs.push_back(make_req(REQ_GAMMA, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0, 5'd31, 8'hFF));
    pending_reqs.push_back(make_req(REQ_GAMMA, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0, 5'd0, 8'h00));
    pending_reqs.push_back(make_req(REQ_GAMMA, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0, 5'd15, 8'h5A));
    pending_reqs.push_back(make_req(REQ_UNUSED, 8'hFF, 5'h1F, 8'hFF, 8'hFF, 8'hFF, 5'h1F,
                                    8'hFF));
    repeat (13)
      pending_reqs.push_back(make_req(REQ_TICK, 8'd0, 5'd0, 8'd0, 8'd0, 8'd0, 5'd0, 8'd0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles less than the receiver stalls
    run_phase(8'd4, 8'd4, 8'd2, 8'd2, MODE_SERIES, 1'b0, 1'b1, 8'($urandom_range(0, 255)),
              150, 55);
    run_phase(8'd3, 8'd6, 8'd3, 8'd3, MODE_PARALLEL, 1'b1, 1'b1, 8'hFF, 150, 60);
    run_phase(8'd1, 8'd2, 8'd1, 8'd1, MODE_SINGLE, 1'b0, 1'b0, 8'h00, 100, 60);

    // swapped idling; deep planes with gamma, then zero and saturated register values
    @(negedge clk_i);
    send_idle_pct  = 54;
    recv_stall_pct = 33;
    run_phase(8'd2, 8'd2, 8'd1, 8'd8, MODE_SINGLE, 1'b1, 1'b0, 8'($urandom_range(0, 255)),
              350, 85);
    run_phase(8'd0, 8'd5, 8'd0, 8'd0, MODE_UNUSED, 1'b0, 1'b1, 8'hFF, 150, 60);
    run_phase(8'd127, 8'd63, 8'd7, 8'd15, MODE_SERIES, 1'b1, 1'b1,
              8'($urandom_range(0, 255)), 80, 70);

    // back to back on both sides
    @(negedge clk_i);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(8'd8, 8'd8, 8'd2, 8'd4, MODE_PARALLEL, 1'b0, 1'b1, 8'($urandom_range(0, 255)),
              230, 60);
    run_phase(8'd64, 8'd32, 8'd4, 8'd1, MODE_SERIES, 1'b0, 1'b0, 8'($urandom_range(0, 255)),
              80, 60);
    run_phase(8'd5, 8'd4, 8'd2, 8'd3, MODE_SINGLE, 1'b1, 1'b1, 8'($urandom_range(0, 255)),
              180, 60);
    run_phase(8'd6, 8'd10, 8'd4, 8'd2, MODE_PARALLEL, 1'b0, 1'b1, 8'($urandom_range(0, 255)),
              180, 60);

    wait_drained();
    repeat (END_CYC) @(posedge clk_i);
    $display("%0d request beats over %0d panel setups, %0d pin words checked",
             accepted_count, geometries, words_checked);
    $display("%0d full frame scans ended, %0d mismatches", frames_seen, err_count);
    if (err_count == 0 && pin_words_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
